// File: rtl/core/uuid_hex_string_parser_top_assert.svh
// Assertion macros for the UUID string parser, empty when synthesized.
`ifndef UUID_HEX_STRING_PARSER_TOP_ASSERT_SVH
`define UUID_HEX_STRING_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check prop at every rising clock edge outside reset.
`define UHSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define UHSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UHSP_ASSERT(label, prop, msg)
`define UHSP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/core/uhsp_pkg.sv
// Types, constants and the hex decoder of the UUID string parser.
package uhsp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } char_t;

    typedef struct packed {
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
        logic [1:0]  size_code;
    } uuid_t;

    localparam logic [1:0] SIZE_INVALID = 2'd0;
    localparam logic [1:0] SIZE_16      = 2'd1;
    localparam logic [1:0] SIZE_32      = 2'd2;
    localparam logic [1:0] SIZE_128     = 2'd3;

    localparam logic [31:0] BASE_HIGH_TAIL = 32'h0000_1000;
    localparam logic [63:0] BASE_LOW       = 64'h8000_0080_5F9B_34FB;

    localparam logic [4:0] NIBBLE_BAD = 5'h10;

    localparam logic [5:0] LEN_SHORT  = 6'd4;
    localparam logic [5:0] LEN_MEDIUM = 6'd8;
    localparam logic [5:0] LEN_FULL   = 6'd32;
    localparam logic [5:0] LEN_DASHED = 6'd36;
    localparam logic [5:0] COUNT_MAX  = 6'd63;
    localparam logic [4:0] BYTES_FULL = 5'd16;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;

    // Bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] decode_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = c - CHAR_ZERO;
            return {1'b0, d[3:0]};
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            d = c - CHAR_LOWER_A + 8'd10;
            return {1'b0, d[3:0]};
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            d = c - CHAR_UPPER_A + 8'd10;
            return {1'b0, d[3:0]};
        end
        return NIBBLE_BAD;
    endfunction

endpackage

// File: rtl/core/uuid_hex_string_parser_top.sv
// UUID string parser: ASCII characters in, one 128-bit UUID and size code per string out.
//
// Usage:
//   char channel: one ASCII character per transaction in char_data.char_code,
//   char_data.last set on the final character of a string.
//   uuid channel: one transaction per string, carrying uuid_high, uuid_low
//   and size_code (zero value and size code 0 for an invalid string).
//   A leading 0x or 0X is stripped; 4 and 8 digit forms land in the base UUID.
//   Data path: a character is held in the input register; the result of a final
//   character is loaded into the output register once it is free, raising uuid_valid.
//   Throughput: one character per cycle, set by the single decode and shift update
//   between the input register and the parser state; a final character is held back
//   while the output register is still full.
//   Reset clears the parser state and both valid flags; the next character
//   starts a new string. A string is also restarted after each result.
//   When the receiver stalls, the result holds; characters that are not
//   final keep flowing, and a final character waits in the input register
//   until the output register is free.
module uuid_hex_string_parser_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           char_valid,
    output logic           char_ready,
    input  uhsp_pkg::char_t char_data,
    output logic           uuid_valid,
    input  logic           uuid_ready,
    output uhsp_pkg::uuid_t uuid_data
);
    import uhsp_pkg::*;

    `include "uuid_hex_string_parser_top_assert.svh"

    // input register
    logic        s1_valid_reg;
    char_t       s1_data_reg;

    // parser state
    logic [5:0]   char_count_reg,     char_count_next;
    logic         zero_first_reg,     zero_first_next;
    logic [127:0] plain_value_reg,    plain_value_next;
    logic         plain_error_reg,    plain_error_next;
    logic [127:0] dashed_value_reg,   dashed_value_next;
    logic [4:0]   dashed_bytes_reg,   dashed_bytes_next;
    logic [4:0]   pending_nibble_reg, pending_nibble_next;
    logic         dashed_error_reg,   dashed_error_next;

    // output register
    logic        out_valid_reg;
    uuid_t       out_data_reg;
    uuid_t       result;

    logic        out_free;
    logic        s1_go;
    logic [7:0]  c;
    logic [4:0]  n;
    logic [3:0]  n_clean;
    logic        clear;
    logic [5:0]  cc_upd;
    logic        zf_upd;
    logic [127:0] pv_upd;
    logic        pe_upd;
    logic [127:0] dv_upd;
    logic [4:0]  db_upd;
    logic [4:0]  pn_upd;
    logic        de_upd;
    logic [5:0]  eff;

    assign out_free   = !out_valid_reg || uuid_ready;
    assign s1_go      = s1_valid_reg && (!s1_data_reg.last || out_free);
    assign char_ready = !s1_valid_reg || s1_go;
    assign uuid_valid = out_valid_reg;
    assign uuid_data  = out_data_reg;

    assign c       = s1_data_reg.char_code;
    assign n       = decode_nibble(c);
    assign n_clean = n[4] ? 4'h0 : n[3:0];

    always_comb
    begin
        zf_upd = zero_first_reg;
        if (char_count_reg == 6'd0)
        begin
            zf_upd = (c == CHAR_ZERO);
        end
        else if (char_count_reg == 6'd1)
        begin
            zf_upd = zero_first_reg && (c == CHAR_LOWER_X || c == CHAR_UPPER_X);
        end
        clear = (char_count_reg == 6'd1) && zf_upd;

        pv_upd = plain_value_reg;
        pe_upd = plain_error_reg;
        dv_upd = dashed_value_reg;
        db_upd = dashed_bytes_reg;
        pn_upd = pending_nibble_reg;
        de_upd = dashed_error_reg;

        if (clear)
        begin
            pv_upd = '0;
            pe_upd = 1'b0;
            dv_upd = '0;
            db_upd = '0;
            pn_upd = '0;
            de_upd = 1'b0;
        end
        else
        begin
            pv_upd = {plain_value_reg[123:0], n_clean};
            pe_upd = plain_error_reg || n[4];
            // dashed reader: pairs of nibbles, dashes allowed between pairs
            if (!dashed_error_reg && dashed_bytes_reg < BYTES_FULL)
            begin
                if (!pending_nibble_reg[4])
                begin
                    if (c == CHAR_DASH)
                    begin
                        pn_upd = pending_nibble_reg;
                    end
                    else if (n[4])
                    begin
                        de_upd = 1'b1;
                    end
                    else
                    begin
                        pn_upd = {1'b1, n[3:0]};
                    end
                end
                else if (n[4])
                begin
                    de_upd = 1'b1;
                end
                else
                begin
                    dv_upd = {dashed_value_reg[119:0], pending_nibble_reg[3:0], n[3:0]};
                    db_upd = dashed_bytes_reg + 5'd1;
                    pn_upd = '0;
                end
            end
        end

        cc_upd = (char_count_reg < COUNT_MAX) ? char_count_reg + 6'd1 : char_count_reg;
        eff    = (cc_upd >= 6'd2 && zf_upd) ? cc_upd - 6'd2 : cc_upd;

        result = '0;
        priority if (eff == LEN_SHORT && !pe_upd)
        begin
            result.uuid_high = {16'h0000, pv_upd[15:0], BASE_HIGH_TAIL};
            result.uuid_low  = BASE_LOW;
            result.size_code = SIZE_16;
        end
        else if (eff == LEN_MEDIUM && !pe_upd)
        begin
            result.uuid_high = {pv_upd[31:0], BASE_HIGH_TAIL};
            result.uuid_low  = BASE_LOW;
            result.size_code = SIZE_32;
        end
        else if (eff == LEN_FULL && !pe_upd)
        begin
            result.uuid_high = pv_upd[127:64];
            result.uuid_low  = pv_upd[63:0];
            result.size_code = SIZE_128;
        end
        else if (eff == LEN_DASHED && !de_upd && db_upd == BYTES_FULL)
        begin
            result.uuid_high = dv_upd[127:64];
            result.uuid_low  = dv_upd[63:0];
            result.size_code = SIZE_128;
        end
        else
        begin
            result = '0;
        end

        char_count_next     = char_count_reg;
        zero_first_next     = zero_first_reg;
        plain_value_next    = plain_value_reg;
        plain_error_next    = plain_error_reg;
        dashed_value_next   = dashed_value_reg;
        dashed_bytes_next   = dashed_bytes_reg;
        pending_nibble_next = pending_nibble_reg;
        dashed_error_next   = dashed_error_reg;
        if (s1_go)
        begin
            if (s1_data_reg.last)
            begin
                // string done: restart
                char_count_next     = '0;
                zero_first_next     = 1'b0;
                plain_value_next    = '0;
                plain_error_next    = 1'b0;
                dashed_value_next   = '0;
                dashed_bytes_next   = '0;
                pending_nibble_next = '0;
                dashed_error_next   = 1'b0;
            end
            else
            begin
                char_count_next     = cc_upd;
                zero_first_next     = zf_upd;
                plain_value_next    = pv_upd;
                plain_error_next    = pe_upd;
                dashed_value_next   = dv_upd;
                dashed_bytes_next   = db_upd;
                pending_nibble_next = pn_upd;
                dashed_error_next   = de_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            char_count_reg     <= '0;
            zero_first_reg     <= 1'b0;
            plain_value_reg    <= '0;
            plain_error_reg    <= 1'b0;
            dashed_value_reg   <= '0;
            dashed_bytes_reg   <= '0;
            pending_nibble_reg <= '0;
            dashed_error_reg   <= 1'b0;
        end
        else
        begin
            if (char_ready)
            begin
                s1_valid_reg <= char_valid;
            end
            if (s1_go && s1_data_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (uuid_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            char_count_reg     <= char_count_next;
            zero_first_reg     <= zero_first_next;
            plain_value_reg    <= plain_value_next;
            plain_error_reg    <= plain_error_next;
            dashed_value_reg   <= dashed_value_next;
            dashed_bytes_reg   <= dashed_bytes_next;
            pending_nibble_reg <= pending_nibble_next;
            dashed_error_reg   <= dashed_error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            s1_data_reg <= char_data;
        end
        if (s1_go && s1_data_reg.last)
        begin
            out_data_reg <= result;
        end
    end

    `UHSP_ASSERT(a_bytes_bound, dashed_bytes_reg <= BYTES_FULL, "dashed byte count past 16")
    `UHSP_ASSERT(a_invalid_zero,
        !out_valid_reg || out_data_reg.size_code != SIZE_INVALID ||
        (out_data_reg.uuid_high == 64'd0 && out_data_reg.uuid_low == 64'd0),
        "invalid result carries a nonzero value")
    `UHSP_ASSERT_NEXT(a_restart, s1_go && s1_data_reg.last,
        char_count_reg == 6'd0 && !dashed_error_reg && !plain_error_reg && out_valid_reg,
        "state not restarted after final character")
    `UHSP_ASSERT(a_ready_when_empty, out_valid_reg || char_ready,
        "input stalled with empty output register")

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the UUID string parser: random strings in, predicted UUIDs checked.
import uhsp_pkg::*;

class uuid_string_checker;
    logic [5:0]   count;
    logic         zero_first;
    logic [127:0] plain;
    logic         plain_err;
    logic [127:0] dashed;
    logic [4:0]   nbytes;
    logic [4:0]   held;
    logic         dashed_err;
    uuid_t        expected_uuids[$];
    int           errors;

    function new();
        errors = 0;
        count = '0;
        zero_first = 1'b0;
        clear_readers();
    endfunction

    function void clear_readers();
        plain = '0;
        plain_err = 1'b0;
        dashed = '0;
        nbytes = '0;
        held = '0;
        dashed_err = 1'b0;
    endfunction

    // Bit 4 flags a character that is not a hex digit.
    function logic [4:0] hex_value(logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            return {1'b0, c[3:0]};
        end
        if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F))
        begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return NIBBLE_BAD;
    endfunction

    function int outstanding();
        return expected_uuids.size();
    endfunction

    function void note_char(char_t ch);
        logic [4:0] nib;
        logic [5:0] eff;
        uuid_t      res;
        nib = hex_value(ch.char_code);
        if (count == 6'd0)
        begin
            zero_first = (ch.char_code == CHAR_ZERO);
        end
        else if (count == 6'd1)
        begin
            zero_first = zero_first &&
                         (ch.char_code == CHAR_LOWER_X || ch.char_code == CHAR_UPPER_X);
        end

        if (count == 6'd1 && zero_first)
        begin
            // drop the 0x prefix and everything the readers took from it
            clear_readers();
        end
        else
        begin
            if (nib[4])
            begin
                plain_err = 1'b1;
            end
            plain = {plain[123:0], nib[4] ? 4'h0 : nib[3:0]};
            if (!dashed_err && nbytes < BYTES_FULL)
            begin
                if (!held[4])
                begin
                    if (ch.char_code != CHAR_DASH)
                    begin
                        if (nib[4])
                        begin
                            dashed_err = 1'b1;
                        end
                        else
                        begin
                            held = {1'b1, nib[3:0]};
                        end
                    end
                end
                else if (nib[4])
                begin
                    dashed_err = 1'b1;
                end
                else
                begin
                    dashed = {dashed[119:0], held[3:0], nib[3:0]};
                    nbytes = nbytes + 5'd1;
                    held = '0;
                end
            end
        end

        if (count != COUNT_MAX)
        begin
            count = count + 6'd1;
        end

        if (ch.last)
        begin
            eff = (count >= 6'd2 && zero_first) ? count - 6'd2 : count;
            res = '0;
            if (eff == LEN_SHORT && !plain_err)
            begin
                res.uuid_high = {16'h0000, plain[15:0], BASE_HIGH_TAIL};
                res.uuid_low = BASE_LOW;
                res.size_code = SIZE_16;
            end
            else if (eff == LEN_MEDIUM && !plain_err)
            begin
                res.uuid_high = {plain[31:0], BASE_HIGH_TAIL};
                res.uuid_low = BASE_LOW;
                res.size_code = SIZE_32;
            end
            else if (eff == LEN_FULL && !plain_err)
            begin
                res.uuid_high = plain[127:64];
                res.uuid_low = plain[63:0];
                res.size_code = SIZE_128;
            end
            else if (eff == LEN_DASHED && !dashed_err && nbytes == BYTES_FULL)
            begin
                res.uuid_high = dashed[127:64];
                res.uuid_low = dashed[63:0];
                res.size_code = SIZE_128;
            end
            expected_uuids.push_back(res);
            count = '0;
            zero_first = 1'b0;
            clear_readers();
        end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("tb: mismatch on %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    task check_uuid(uuid_t got);
        uuid_t want;
        if (expected_uuids.size() == 0)
        begin
            report("uuid with none pending", got.uuid_high, '0);
            return;
        end
        want = expected_uuids.pop_front();
        if (got.uuid_high !== want.uuid_high)
        begin
            report("uuid_high", got.uuid_high, want.uuid_high);
        end
        if (got.uuid_low !== want.uuid_low)
        begin
            report("uuid_low", got.uuid_low, want.uuid_low);
        end
        if (got.size_code !== want.size_code)
        begin
            report("size_code", 64'(got.size_code), 64'(want.size_code));
        end
    endtask
endclass

module tb;
    localparam int ITEM_TARGET    = 1400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  char_valid = 1'b0;
    logic  char_ready;
    char_t char_data = '0;
    logic  uuid_valid;
    logic  uuid_ready = 1'b0;
    uuid_t uuid_data;

    uuid_string_checker sb;
    logic [7:0] text[$];
    int         chars_sent = 0;
    int         strings = 0;
    int         stalled = 0;
    bit         steady = 1'b0;

    uuid_hex_string_parser_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .uuid_valid (uuid_valid),
        .uuid_ready (uuid_ready),
        .uuid_data  (uuid_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        uuid_ready <= steady || ($urandom_range(0, 99) >= 25);
    end

    // Monitor both channels and watch for a hung handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && char_ready)
            begin
                sb.note_char(char_data);
            end
            if (uuid_valid && uuid_ready)
            begin
                sb.check_uuid(uuid_data);
            end
            if ((char_valid && char_ready) || (uuid_valid && uuid_ready))
            begin
                stalled = 0;
            end
            else
            begin
                stalled++;
            end
            if (stalled >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [7:0] hex_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 10)
        begin
            return CHAR_ZERO + 8'(n);
        end
        return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(n - 10);
    endfunction

    task automatic put_hex(input int n);
        repeat (n) text.push_back(hex_char());
    endtask

    task automatic put_string(input string s);
        foreach (s[i]) text.push_back(s[i]);
    endtask

    // 16 hex pairs with four dashes, either in the 8-4-4-4-12 layout or at random pair boundaries.
    task automatic put_dashed(input bit canonical);
        int dash_at[17];
        foreach (dash_at[i]) dash_at[i] = 0;
        if (canonical)
        begin
            dash_at[4] = 1;
            dash_at[6] = 1;
            dash_at[8] = 1;
            dash_at[10] = 1;
        end
        else
        begin
            repeat (4) dash_at[$urandom_range(0, 16)]++;
        end
        for (int p = 0; p <= 16; p++)
        begin
            repeat (dash_at[p]) text.push_back(CHAR_DASH);
            if (p < 16)
            begin
                put_hex(2);
            end
        end
    endtask

    task automatic send_char(input logic [7:0] code, input logic fin);
        char_t item;
        item.char_code = code;
        item.last = fin;
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_data <= item;
        @(posedge clk);
        while (!char_ready) @(posedge clk);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
        text.delete();
        strings++;
    endtask

    // Hold the sender until every pending UUID has come out.
    task automatic drain();
        char_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0) @(negedge clk);
    endtask

    initial
    begin
        int pick;
        int m;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // prefixes, short forms, extreme codes, an empty body after the prefix, a lone zero
        put_string("0x180d");
        send_text();
        put_string("0XFFff");
        send_text();
        put_string("9aF0Bc17");
        send_text();
        text.push_back(8'h00);
        send_text();
        text.push_back(8'hFF);
        send_text();
        put_string("0x");
        send_text();
        put_string("0");
        send_text();
        drain();

        while (chars_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 86 && $urandom_range(0, 9) < 4)
            begin
                text.push_back(CHAR_ZERO);
                text.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
            end
            if (pick < 12)
            begin
                put_hex(4);
            end
            else if (pick < 24)
            begin
                put_hex(8);
            end
            else if (pick < 42)
            begin
                put_hex(32);
            end
            else if (pick < 56)
            begin
                put_dashed(1'b1);
            end
            else if (pick < 66)
            begin
                put_dashed(1'b0);
            end
            else if (pick < 76)
            begin
                // 36 characters with dashes anywhere, inside pairs too
                m = $urandom_range(0, 8);
                put_hex(36 - m);
                repeat (m) text.insert($urandom_range(0, text.size()), CHAR_DASH);
            end
            else if (pick < 86)
            begin
                case ($urandom_range(0, 3))
                    0: put_hex(4);
                    1: put_hex(8);
                    2: put_hex(32);
                    default: put_dashed(1'b1);
                endcase
                text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 40)) text.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick < 98)
            begin
                put_hex($urandom_range(1, 40));
            end
            else
            begin
                // 60 to 70 digits, often enough to saturate the character count
                put_hex($urandom_range(60, 70));
            end
            steady = (strings >= 20 && strings < 36);
            send_text();
            if ($urandom_range(0, 9) == 0)
            begin
                drain();
            end
        end
        steady = 1'b0;
        char_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: uuid_hex_string_parser_top.f
+incdir+rtl/core
rtl/core/uhsp_pkg.sv
rtl/core/uuid_hex_string_parser_top.sv
tb/sv/tb.sv
